// ===== hdl/nabmd_pkg.sv =====
`default_nettype none
package nabmd_pkg;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int SUM_W = 40;
   localparam int COUNT_W = 9;
   localparam int DIM_W = 13;
   localparam int POS_W = 12;
   localparam int MIP_W = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int MAX_IMAGE_HEIGHT = 4096;

   // shared divider geometry
   localparam int DIV_N_W = SUM_W;
   localparam int DIV_D_W = COUNT_W;
   localparam int DIV_CNT_W = 6;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_REGION_X      = 3'd2,
      REG_REGION_Y      = 3'd3,
      REG_REGION_WIDTH  = 3'd4,
      REG_REGION_HEIGHT = 3'd5,
      REG_MIP           = 3'd6,
      REG_FILTER_MODE   = 3'd7
   } reg_index_type;

   // filter modes
   localparam logic MODE_NEAREST = 1'b0;
   localparam logic MODE_MEAN = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DX,
      S_DY,
      S_CW,
      S_CH,
      S_RANGE,
      S_RD,
      S_UPD,
      S_MEAN,
      S_OUT
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/nabmd_div.sv =====
`default_nettype none
module nabmd_div
   import nabmd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient,
   output logic [DIV_D_W-1:0]      remainder
);

   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_N_W-1:0]   quo_ff;
   logic [DIV_D_W-1:0]   dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_D_W:0]     trial;
   logic                 fits;
   logic [DIV_D_W:0]     diff;

   // one restoring step per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_N_W-1]};
      fits = trial >= {1'b0, dsr_ff};
      diff = trial - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quo_ff <= {quo_ff[DIV_N_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== hdl/nabmd_mem.sv =====
`default_nettype none
module nabmd_mem
   import nabmd_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW = 12
)(
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [SUM_W+COUNT_W-1:0]   wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic [SUM_W+COUNT_W-1:0]        rd_data
);

   // per block column: {sum, count}
   logic [SUM_W+COUNT_W-1:0] mem [DEPTH];
   logic [SUM_W+COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/nan_aware_block_mean_downsampler.sv =====
`default_nettype none
// channel | dir | tdata (low bit up)                    | tuser       | tlast
// req     | in  | pixel_value[31:0], pixel_finite[32]    | frame_start | -
// rsp     | out | out_value[31:0], out_valid[32]        | -           | out_last
// csr     | in  | write enable, 3-bit index, 13-bit data | -           | -
// One pixel at a time: the next pixel is taken only when the sequencer is back in idle.
// Each pixel that passes the check makes four 40-step passes of the shared radix-2
// divider, plus one more pass for the mean when it closes its block. Bad settings or a
// pixel left of or above the region are dropped at the check.
// Block sums and counts sit in a one-port-read, one-port-write RAM.
// Synchronous active-high reset clears the sequencer, position and registers; the RAM
// is not cleared. A held result stops no new pixel until the next result must wait for it.
module nan_aware_block_mean_downsampler
   import nabmd_pkg::*;
#(
   parameter int MAX_IMAGE_WIDTH = 4096,
   parameter int MAX_MIP = 16,
   parameter int MAX_OUT_COLUMNS = 4096
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [39:0]           req_tdata,   // pixel_value[31:0], pixel_finite[32]
   input  wire logic                  req_tuser,   // frame_start
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata,   // out_value[31:0], out_valid[32]
   output logic                       rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;

   // configuration
   logic [DIM_W-1:0] img_w_ff, img_h_ff, reg_w_ff, reg_h_ff;
   logic [POS_W-1:0] reg_x_ff, reg_y_ff;
   logic [MIP_W-1:0] mip_ff;
   logic             mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= DIM_W'(4096);
         img_h_ff <= DIM_W'(4096);
         reg_x_ff <= '0;
         reg_y_ff <= '0;
         reg_w_ff <= DIM_W'(4096);
         reg_h_ff <= DIM_W'(4096);
         mip_ff <= MIP_W'(1);
         mode_ff <= MODE_MEAN;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_IMAGE_WIDTH:   img_w_ff <= csr_wdata;
            REG_IMAGE_HEIGHT:  img_h_ff <= csr_wdata;
            REG_REGION_X:      reg_x_ff <= csr_wdata[POS_W-1:0];
            REG_REGION_Y:      reg_y_ff <= csr_wdata[POS_W-1:0];
            REG_REGION_WIDTH:  reg_w_ff <= csr_wdata;
            REG_REGION_HEIGHT: reg_h_ff <= csr_wdata;
            REG_MIP:           mip_ff <= csr_wdata[MIP_W-1:0];
            REG_FILTER_MODE:   mode_ff <= csr_wdata[0];
            default:           mode_ff <= mode_ff;
         endcase
      end
   end

   state_type state_ff, state_in;

   // latched pixel and its position
   logic [VALUE_W-1:0] pix_ff;
   logic               fin_ff;
   logic [POS_W-1:0]   c_ff, r_ff;
   logic [POS_W-1:0]   scan_c_ff, scan_r_ff;
   logic [POS_W-1:0]   cur_c, cur_r;
   logic [DIM_W-1:0]   nxt_c, nxt_r;
   logic               take;

   assign req_tready = (state_ff == S_IDLE);
   assign take = req_tvalid && req_tready;

   always_comb begin
      cur_c = req_tuser ? '0 : scan_c_ff;
      cur_r = req_tuser ? '0 : scan_r_ff;
      nxt_c = {1'b0, cur_c} + 1'b1;
      nxt_r = {1'b0, cur_r};
      if (nxt_c >= img_w_ff) begin
         nxt_c = '0;
         nxt_r = {1'b0, cur_r} + 1'b1;
         if (nxt_r >= img_h_ff) begin
            nxt_r = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_c_ff <= '0;
         scan_r_ff <= '0;
      end else if (take) begin
         scan_c_ff <= nxt_c[POS_W-1:0];
         scan_r_ff <= nxt_r[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pix_ff <= req_tdata[VALUE_W-1:0];
         fin_ff <= req_tdata[VALUE_W];
         c_ff <= cur_c;
         r_ff <= cur_r;
      end
   end

   // settings and position check
   logic ok;
   always_comb begin
      ok = (img_w_ff != '0) && (img_h_ff != '0)
         && (32'(img_w_ff) <= MAX_IMAGE_WIDTH) && (32'(img_h_ff) <= MAX_IMAGE_HEIGHT)
         && (mip_ff != '0) && (32'(mip_ff) <= MAX_MIP)
         && ({1'b0, reg_x_ff} + {1'b0, reg_w_ff} <= {1'b0, img_w_ff})
         && ({1'b0, reg_y_ff} + {1'b0, reg_h_ff} <= {1'b0, img_h_ff})
         && ({1'b0, c_ff} < img_w_ff) && ({1'b0, r_ff} < img_h_ff)
         && (c_ff >= reg_x_ff) && (r_ff >= reg_y_ff);
   end

   // shared divider
   logic               div_start, div_done;
   logic [DIV_N_W-1:0] div_n, div_q;
   logic [DIV_D_W-1:0] div_d, div_r;

   nabmd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // block coordinates
   logic [POS_W-1:0] i_ff, j_ff;
   logic             dxz_ff, dyz_ff;
   logic [DIM_W-1:0] cols_ff, rows_ff;
   logic             last_ff;

   // block memory
   logic                     mem_we, mem_re;
   logic [SUM_W+COUNT_W-1:0] mem_wd, mem_rd;
   logic [SUM_W-1:0]         acc_sum;
   logic [COUNT_W-1:0]       acc_cnt;
   logic                     sum_neg_ff;

   nabmd_mem #(.DEPTH(MAX_OUT_COLUMNS), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(i_ff)),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (AW'(i_ff)),
      .rd_data (mem_rd)
   );

   // read-modify of the block entry
   logic [SUM_W-1:0]   base_sum;
   logic [COUNT_W-1:0] base_cnt;
   logic [18:0]        endc, endr;
   logic               at_end;
   always_comb begin
      base_sum = (dxz_ff && dyz_ff) ? '0 : mem_rd[SUM_W+COUNT_W-1:COUNT_W];
      base_cnt = (dxz_ff && dyz_ff) ? '0 : mem_rd[COUNT_W-1:0];
      acc_sum = fin_ff ? base_sum + SUM_W'($signed(pix_ff)) : base_sum;
      acc_cnt = fin_ff ? base_cnt + 1'b1 : base_cnt;
      mem_wd = {acc_sum, acc_cnt};
      endc = 19'(reg_x_ff) + 19'((14'(i_ff) + 14'd1) * 14'(mip_ff));
      if (endc > 19'(img_w_ff)) endc = 19'(img_w_ff);
      endr = 19'(reg_y_ff) + 19'((14'(j_ff) + 14'd1) * 14'(mip_ff));
      if (endr > 19'(img_h_ff)) endr = 19'(img_h_ff);
      at_end = (19'(c_ff) == endc - 19'd1) && (19'(r_ff) == endr - 19'd1);
   end

   // mean: sign, magnitude back, saturate
   logic [SUM_W:0]     mean_s;
   logic [VALUE_W-1:0] mean_v;
   always_comb begin
      mean_s = sum_neg_ff ? -{1'b0, div_q} : {1'b0, div_q};
      if (!sum_neg_ff && (div_q > SUM_W'(32'h7FFF_FFFF))) begin
         mean_v = 32'h7FFF_FFFF;
      end else if (sum_neg_ff && (div_q > SUM_W'(33'h0_8000_0000))) begin
         mean_v = 32'h8000_0000;
      end else begin
         mean_v = mean_s[VALUE_W-1:0];
      end
   end

   // result staging and output register
   logic [VALUE_W-1:0] res_v_ff, res_v_in;
   logic               res_ok_ff, res_ok_in;
   logic               out_v_ff, out_last_ff, out_ok_ff;
   logic [VALUE_W-1:0] out_val_ff;
   logic               out_load;

   // sequencer
   always_comb begin
      state_in = state_ff;
      div_n = '0;
      div_d = DIV_D_W'(mip_ff);
      mem_we = 1'b0;
      mem_re = 1'b0;
      res_v_in = res_v_ff;
      res_ok_in = res_ok_ff;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE:  if (take) state_in = S_CHECK;
         S_CHECK: state_in = ok ? S_DX : S_IDLE;
         S_DX:    if (div_done) state_in = S_DY;
         S_DY:    if (div_done) state_in = S_CW;
         S_CW:    if (div_done) state_in = S_CH;
         S_CH:    if (div_done) state_in = S_RANGE;
         S_RANGE: begin
            if (13'(i_ff) >= cols_ff || 13'(j_ff) >= rows_ff) begin
               state_in = S_IDLE;
            end else if (mode_ff == MODE_MEAN && mip_ff > MIP_W'(1)) begin
               state_in = (32'(i_ff) >= MAX_OUT_COLUMNS) ? S_IDLE : S_RD;
            end else if (dxz_ff && dyz_ff) begin
               res_v_in = fin_ff ? pix_ff : '0;
               res_ok_in = fin_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            mem_re = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            mem_we = 1'b1;
            if (!at_end) begin
               state_in = S_IDLE;
            end else if (acc_cnt == '0) begin
               res_v_in = '0;
               res_ok_in = 1'b0;
               state_in = S_OUT;
            end else begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            if (div_done) begin
               res_v_in = mean_v;
               res_ok_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_v_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // divider operands follow the state being entered
      unique case (state_in)
         S_DX:    div_n = DIV_N_W'(c_ff - reg_x_ff);
         S_DY:    div_n = DIV_N_W'(r_ff - reg_y_ff);
         S_CW:    div_n = DIV_N_W'(14'(reg_w_ff) + 14'(mip_ff) - 14'd1);
         S_CH:    div_n = DIV_N_W'(14'(reg_h_ff) + 14'(mip_ff) - 14'd1);
         S_MEAN: begin
            div_n = acc_sum[SUM_W-1] ? -acc_sum : acc_sum;
            div_d = acc_cnt;
         end
         default: div_n = '0;
      endcase
   end

   assign div_start = (state_in != state_ff) && (state_in == S_DX || state_in == S_DY
                      || state_in == S_CW || state_in == S_CH || state_in == S_MEAN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture divider results
   always_ff @(posedge clock) begin
      res_v_ff <= res_v_in;
      res_ok_ff <= res_ok_in;
      if (state_ff == S_DX && div_done) begin
         i_ff <= div_q[POS_W-1:0];
         dxz_ff <= (div_r == '0);
      end
      if (state_ff == S_DY && div_done) begin
         j_ff <= div_q[POS_W-1:0];
         dyz_ff <= (div_r == '0);
      end
      if (state_ff == S_CW && div_done) cols_ff <= div_q[DIM_W-1:0];
      if (state_ff == S_CH && div_done) rows_ff <= div_q[DIM_W-1:0];
      if (state_ff == S_RANGE) begin
         last_ff <= (13'(i_ff) == cols_ff - 1'b1) && (13'(j_ff) == rows_ff - 1'b1);
      end
      if (state_ff == S_UPD) sum_neg_ff <= acc_sum[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_load) begin
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_val_ff <= res_v_ff;
         out_ok_ff <= res_ok_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {7'd0, out_ok_ff, out_val_ff};
   assign rsp_tlast = out_last_ff;

`ifndef SYNTHESIS
   // a NaN result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[VALUE_W] |-> rsp_tdata[VALUE_W-1:0] == '0)
      else $error("NaN result with nonzero value");

   // one pixel in flight
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second pixel taken while busy");

   // memory written only on the mean path
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> mode_ff == MODE_MEAN && mip_ff > MIP_W'(1))
      else $error("block memory written outside mean mode");

   // divider finishes only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DX || state_ff == S_DY || state_ff == S_CW
                   || state_ff == S_CH || state_ff == S_MEAN)
      else $error("divider result not expected");
`endif

endmodule
`default_nettype wire

// ===== test/nan_aware_block_mean_downsampler_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module nan_aware_block_mean_downsampler_checker
   import nabmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [39:0]           req_tdata,   // pixel_value[31:0], pixel_finite[32]
   input  wire logic                  req_tuser,   // frame_start
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [39:0]           rsp_tdata,   // out_value[31:0], out_valid[32]
   input  wire logic                  rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending,
   output int                         result_count
);

   typedef struct {
      logic [31:0] value;
      logic        valid;
      logic        last;
   } block_result_type;

   // shadow registers
   int unsigned img_w, img_h, reg_x, reg_y, reg_w, reg_h, factor;
   logic        mode;

   // shadow block row accumulators and scan position
   logic signed [SUM_W-1:0] blk_sum [4096];
   logic [COUNT_W-1:0]      blk_count [4096];
   int unsigned             scan_col, scan_row;

   block_result_type expected_blocks [$];

   assign pending = expected_blocks.size();

   // one pixel through the shadow downsampler
   task automatic downsample_pixel(logic [31:0] raw, logic fin, logic fs);
      int unsigned c, r, nc, nr, dx, dy, i, j, cols, rows, endc, endr;
      longint q;
      bit ok, lst;
      block_result_type e;
      c = scan_col;
      r = scan_row;
      if (fs) begin
         c = 0;
         r = 0;
      end
      nc = c + 1;
      nr = r;
      if (nc >= img_w) begin
         nc = 0;
         nr = r + 1;
         if (nr >= img_h) nr = 0;
      end
      scan_col = nc & 12'hfff;
      scan_row = nr & 12'hfff;

      ok = img_w >= 1 && img_h >= 1 && img_w <= 4096 && img_h <= MAX_IMAGE_HEIGHT &&
           factor >= 1 && factor <= 16 && reg_x + reg_w <= img_w && reg_y + reg_h <= img_h;
      if (!ok || c >= img_w || r >= img_h || c < reg_x || r < reg_y) return;
      dx = c - reg_x;
      dy = r - reg_y;
      i = dx / factor;
      j = dy / factor;
      cols = (reg_w + factor - 1) / factor;
      rows = (reg_h + factor - 1) / factor;
      if (i >= cols || j >= rows) return;
      lst = (i == cols - 1) && (j == rows - 1);

      if (mode == MODE_MEAN && factor > 1) begin
         if (i >= 4096) return;
         if (dx % factor == 0 && dy % factor == 0) begin
            blk_sum[i] = '0;
            blk_count[i] = '0;
         end
         if (fin) begin
            blk_sum[i] = blk_sum[i] + SUM_W'($signed(raw));
            blk_count[i] = blk_count[i] + 1'b1;
         end
         endc = reg_x + (i + 1) * factor;
         if (endc > img_w) endc = img_w;
         endr = reg_y + (j + 1) * factor;
         if (endr > img_h) endr = img_h;
         if (c != endc - 1 || r != endr - 1) return;
         if (blk_count[i] == 0) begin
            e.value = '0;
            e.valid = 1'b0;
         end else begin
            q = longint'(blk_sum[i]) / longint'({1'b0, blk_count[i]});
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            e.value = q[31:0];
            e.valid = 1'b1;
         end
         e.last = lst;
         expected_blocks.insert(expected_blocks.size(), e);
         return;
      end

      // nearest, or mean at mip 1: top-left pixel of each block
      if (dx % factor != 0 || dy % factor != 0) return;
      e.value = fin ? raw : '0;
      e.valid = fin;
      e.last = lst;
      expected_blocks.insert(expected_blocks.size(), e);
   endtask

   always @(posedge clock) begin
      block_result_type e;
      if (reset) begin
         img_w = 4096; img_h = 4096; reg_x = 0; reg_y = 0;
         reg_w = 4096; reg_h = 4096; factor = 1; mode = MODE_MEAN;
         scan_col = 0; scan_row = 0;
         expected_blocks.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (reg_index_type'(csr_addr))
               REG_IMAGE_WIDTH:   img_w = 32'(csr_wdata);
               REG_IMAGE_HEIGHT:  img_h = 32'(csr_wdata);
               REG_REGION_X:      reg_x = 32'(csr_wdata[11:0]);
               REG_REGION_Y:      reg_y = 32'(csr_wdata[11:0]);
               REG_REGION_WIDTH:  reg_w = 32'(csr_wdata);
               REG_REGION_HEIGHT: reg_h = 32'(csr_wdata);
               REG_MIP:           factor = 32'(csr_wdata[4:0]);
               REG_FILTER_MODE:   mode = csr_wdata[0];
               default: ;
            endcase
         end
         // result transfer against oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_blocks.size() == 0) begin
               $error("unexpected result transfer: value %h valid %b last %b",
                      rsp_tdata[31:0], rsp_tdata[32], rsp_tlast);
               fail_count++;
            end else begin
               e = expected_blocks.pop_front();
               if (rsp_tdata[31:0] !== e.value) begin
                  $error("out_value: expected %h actual %h", e.value, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[32] !== e.valid) begin
                  $error("out_valid: expected %b actual %b", e.valid, rsp_tdata[32]);
                  fail_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("out_last: expected %b actual %b", e.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         // pixel transfer
         if (req_tvalid && req_tready)
            downsample_pixel(req_tdata[31:0], req_tdata[32], req_tuser);
      end
   end

   initial begin
      fail_count = 0;
      result_count = 0;
   end

endmodule
`default_nettype wire

// ===== test/nan_aware_block_mean_downsampler_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module nan_aware_block_mean_downsampler_test;
   import nabmd_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;   // pixel_value[31:0], pixel_finite[32]
   logic                  req_tuser = 1'b0; // frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;        // out_value[31:0], out_valid[32]
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count, pending, result_count;
   int pixels_sent = 0;
   int setting_count = 0;
   int send_idle_pct = 38;
   int recv_idle_pct = 65;

   always #5 clock = ~clock;

   nan_aware_block_mean_downsampler dut (.*);

   nan_aware_block_mean_downsampler_checker checker_inst (.*);

   // receiver back-pressure
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // one pixel transfer; returns at the falling edge after acceptance
   task automatic send_pixel(logic [31:0] value, logic fin, logic fs);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tdata <= {7'd0, fin, value};
      req_tuser <= fs;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      pixels_sent++;
      if (pixels_sent == 650) begin
         send_idle_pct = 65;
         recv_idle_pct = 38;
      end else if (pixels_sent == 1300) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // drain, let a pixel in flight finish, then write all registers
   task automatic apply_settings(int w, int h, int x, int y, int rw, int rh, int m, int md);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= REG_IMAGE_WIDTH;   csr_wdata <= CSR_DATA_W'(w);  @(negedge clock);
      csr_addr <= REG_IMAGE_HEIGHT;  csr_wdata <= CSR_DATA_W'(h);  @(negedge clock);
      csr_addr <= REG_REGION_X;      csr_wdata <= CSR_DATA_W'(x);  @(negedge clock);
      csr_addr <= REG_REGION_Y;      csr_wdata <= CSR_DATA_W'(y);  @(negedge clock);
      csr_addr <= REG_REGION_WIDTH;  csr_wdata <= CSR_DATA_W'(rw); @(negedge clock);
      csr_addr <= REG_REGION_HEIGHT; csr_wdata <= CSR_DATA_W'(rh); @(negedge clock);
      csr_addr <= REG_MIP;           csr_wdata <= CSR_DATA_W'(m);  @(negedge clock);
      csr_addr <= REG_FILTER_MODE;   csr_wdata <= CSR_DATA_W'(md); @(negedge clock);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   // random pixel with a bias toward extremes
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 255) << 16;
         3: return -($urandom_range(0, 255) << 16);
         default: return $urandom;
      endcase
   endfunction

   // whole frames with random content, stopping at the pixel budget
   task automatic send_frames(int w, int h, int frames, int nan_pct);
      for (int f = 0; f < frames; f++)
         for (int p = 0; p < w * h && pixels_sent < 1950; p++)
            send_pixel(pick_value(), $urandom_range(99) >= nan_pct,
                       p == 0 || (p > 0 && $urandom_range(199) == 0 && 0));
   endtask

   initial begin
      int w, h, x, y, rw, rh, m, md, nan_pct;
      logic [31:0] corner [4];
      corner = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: mean at mip 1 (the nearest path) over a huge image, first few pixels
      send_pixel(32'h7fffffff, 1'b1, 1'b1);
      send_pixel(32'h80000000, 1'b1, 1'b0);
      send_pixel(32'h12345678, 1'b0, 1'b0);

      // 4x4 mean, mip 2: extreme-value, mixed, all-NaN and partial-NaN blocks
      apply_settings(4, 4, 0, 0, 4, 4, 2, MODE_MEAN);
      for (int p = 0; p < 16; p++)
         send_pixel(((p % 4) < 2) ? ((p < 8) ? 32'h7fffffff : 32'h80000000) : corner[p % 4],
                    !((p % 4) >= 2 && p >= 8) && p != 2, p == 0);

      // largest image and region corner: position never reaches the region
      apply_settings(4096, 4096, 4095, 4095, 1, 1, 16, MODE_MEAN);
      send_pixel(32'h0, 1'b1, 1'b1);
      send_pixel(32'h1, 1'b1, 1'b0);

      // random settings, mostly valid, some bad or empty
      while (pixels_sent < 1950) begin
         w = $urandom_range(1, 20);
         h = $urandom_range(1, 20);
         x = $urandom_range(0, w - 1);
         y = $urandom_range(0, h - 1);
         rw = $urandom_range(1, w - x);
         rh = $urandom_range(1, h - y);
         m = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
         md = $urandom_range(1);
         case ($urandom_range(19))
            0: m = 16;
            1: m = ($urandom_range(1) != 0) ? 0 : $urandom_range(17, 31);
            2: rw = 0;
            3: rh = $urandom_range(1) ? 0 : h - y + 1;
            4: begin
               x = 0; y = 0; rw = w; rh = h;
            end
            default: ;
         endcase
         nan_pct = ($urandom_range(3) == 0) ? 80 : 10;
         apply_settings(w, h, x, y, rw, rh, m, md);
         send_frames(w, h, $urandom_range(1, 2), nan_pct);
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      $display("Sent %0d pixels under %0d register settings; %0d block results checked.",
               pixels_sent, setting_count, result_count);
      if (fail_count == 0) begin
         $display("nan_aware_block_mean_downsampler_test passed");
      end else begin
         $display("nan_aware_block_mean_downsampler_test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #60000000;
      $display("nan_aware_block_mean_downsampler_test failed");
      $finish;
   end

endmodule
`default_nettype wire
